// ===== rtl/sbt_pkg.sv =====
// ---------------------------------------------------------------------------
// sbt_pkg
// shared types and constants of the source byte tokenizer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbt_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] text_length;
        logic [15:0] line_number;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  first;
        t_out_item  second;
    } t_push;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_EOS  = 1'b1;

    localparam logic [3:0] KIND_IDENT  = 4'd0;
    localparam logic [3:0] KIND_USE    = 4'd1;
    localparam logic [3:0] KIND_FN     = 4'd2;
    localparam logic [3:0] KIND_STRING = 4'd3;
    localparam logic [3:0] KIND_LPAREN = 4'd4;
    localparam logic [3:0] KIND_RPAREN = 4'd5;
    localparam logic [3:0] KIND_LBRACE = 4'd6;
    localparam logic [3:0] KIND_RBRACE = 4'd7;
    localparam logic [3:0] KIND_DOT    = 4'd8;
    localparam logic [3:0] KIND_SEMI   = 4'd9;
    localparam logic [3:0] KIND_COMMA  = 4'd10;
    localparam logic [3:0] KIND_COLON  = 4'd11;
    localparam logic [3:0] KIND_UNTERM = 4'd12;
    localparam logic [3:0] KIND_EOF    = 4'd13;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

endpackage

`default_nettype wire

// ===== rtl/sbt_scan.sv =====
// ---------------------------------------------------------------------------
// sbt_scan
// scan state and per-byte token decision, up to two tokens per transfer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbt_scan import sbt_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_go,
    input  wire t_in_item i_item,
    output t_push         o_push
);

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_IDENT  = 3'b010,
        MODE_STRING = 3'b100
    } t_mode;

    localparam logic [2:0] KW_NONE = 3'd0;
    localparam logic [2:0] KW_U    = 3'd1;
    localparam logic [2:0] KW_US   = 3'd2;
    localparam logic [2:0] KW_USE  = 3'd3;
    localparam logic [2:0] KW_F    = 3'd4;
    localparam logic [2:0] KW_FN   = 3'd5;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_USCORE = 8'h5f;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_LO_S   = 8'h73;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6e;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [15:0]              r_line, n_line;
    logic [15:0]              r_len, n_len;
    logic [2:0]               r_kw, n_kw;

    logic [7:0]               b;
    logic                     is_alpha, is_start, is_more, is_quote, is_nl;
    logic                     pk_valid;
    logic [3:0]               pk_kind;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [15:0]              line_inc, len_inc;
    logic [POSITION_BITS+15:0] pos_ext, start_ext;
    logic [15:0]              pos16, start16;
    logic [3:0]               id_kind;
    logic [2:0]               kw_first, kw_next;
    logic                     a_v, b_v;
    t_out_item                a_tok, b_tok, id_tok;

    assign b        = i_item.data_byte;
    assign is_alpha = (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
    assign is_start = is_alpha || (b == CH_USCORE);
    assign is_more  = is_start || (b >= 8'h30 && b <= 8'h39);
    assign is_quote = (b == CH_QUOTE);
    assign is_nl    = (b == CH_NL);

    assign pos_inc  = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign line_inc = (r_line == 16'hffff) ? r_line : r_line + 16'd1;
    assign len_inc  = (r_len == 16'hffff) ? r_len : r_len + 16'd1;

    // offsets are reported modulo 2^16
    assign pos_ext   = {16'b0, r_pos};
    assign start_ext = {16'b0, r_start};
    assign pos16     = pos_ext[15:0];
    assign start16   = start_ext[15:0];

    always_comb begin
        pk_valid = 1'b1;
        case (b)
            CH_LPAREN: pk_kind = KIND_LPAREN;
            CH_RPAREN: pk_kind = KIND_RPAREN;
            CH_LBRACE: pk_kind = KIND_LBRACE;
            CH_RBRACE: pk_kind = KIND_RBRACE;
            CH_DOT:    pk_kind = KIND_DOT;
            CH_SEMI:   pk_kind = KIND_SEMI;
            CH_COMMA:  pk_kind = KIND_COMMA;
            CH_COLON:  pk_kind = KIND_COLON;
            default: begin
                pk_valid = 1'b0;
                pk_kind  = KIND_IDENT;
            end
        endcase
    end

    always_comb begin
        case (b)
            CH_LO_U: kw_first = KW_U;
            CH_LO_F: kw_first = KW_F;
            default: kw_first = KW_NONE;
        endcase
    end

    always_comb begin
        kw_next = KW_NONE;
        case (r_kw)
            KW_U:    if (b == CH_LO_S) kw_next = KW_US;
            KW_US:   if (b == CH_LO_E) kw_next = KW_USE;
            KW_F:    if (b == CH_LO_N) kw_next = KW_FN;
            default: kw_next = KW_NONE;
        endcase
    end

    always_comb begin
        case (r_kw)
            KW_USE:  id_kind = KIND_USE;
            KW_FN:   id_kind = KIND_FN;
            default: id_kind = KIND_IDENT;
        endcase
    end

    assign id_tok = '{token_kind: id_kind, start_offset: start16, text_length: r_len,
                      line_number: r_line, last_of_run: 1'b0};

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_line  = r_line;
        n_len   = r_len;
        n_kw    = r_kw;
        a_v     = 1'b0;
        b_v     = 1'b0;
        a_tok   = id_tok;
        b_tok   = '{token_kind: KIND_EOF, start_offset: pos16, text_length: 16'd0,
                    line_number: r_line, last_of_run: 1'b0};
        if (i_go) begin
            if (i_item.cmd == CMD_EOS) begin
                // flush the pending token, then end of file, then back to reset
                a_v = (r_mode != MODE_IDLE);
                if (r_mode == MODE_STRING) begin
                    a_tok.token_kind = KIND_UNTERM;
                end
                b_v     = 1'b1;
                n_mode  = MODE_IDLE;
                n_pos   = '0;
                n_start = '0;
                n_line  = 16'd1;
                n_len   = 16'd0;
                n_kw    = KW_NONE;
            end else begin
                n_pos = pos_inc;
                case (r_mode)
                    MODE_STRING: begin
                        if (is_quote) begin
                            a_v              = 1'b1;
                            a_tok.token_kind = KIND_STRING;
                            n_mode           = MODE_IDLE;
                        end else begin
                            if (is_nl) begin
                                n_line = line_inc;
                            end
                            n_len = len_inc;
                        end
                    end
                    default: begin
                        if (r_mode == MODE_IDENT && is_more) begin
                            n_kw  = kw_next;
                            n_len = len_inc;
                        end else begin
                            if (r_mode == MODE_IDENT) begin
                                a_v    = 1'b1;
                                n_mode = MODE_IDLE;
                            end
                            if (is_start) begin
                                n_mode  = MODE_IDENT;
                                n_start = r_pos;
                                n_len   = 16'd1;
                                n_kw    = kw_first;
                            end else if (is_quote) begin
                                n_mode  = MODE_STRING;
                                n_start = pos_inc;
                                n_len   = 16'd0;
                                n_kw    = KW_NONE;
                            end else if (is_nl) begin
                                n_line = line_inc;
                            end else if (pk_valid) begin
                                b_v   = 1'b1;
                                b_tok = '{token_kind: pk_kind, start_offset: pos16,
                                          text_length: 16'd1, line_number: r_line,
                                          last_of_run: 1'b0};
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_push.cnt                = {1'b0, a_v} + {1'b0, b_v};
        o_push.first              = a_v ? a_tok : b_tok;
        o_push.first.last_of_run  = !(a_v && b_v);
        o_push.second             = b_tok;
        o_push.second.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_line  <= 16'd1;
            r_len   <= 16'd0;
            r_kw    <= KW_NONE;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_line  <= n_line;
            r_len   <= n_len;
            r_kw    <= n_kw;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sbt_oq.sv =====
// ---------------------------------------------------------------------------
// sbt_oq
// small token queue, up to two writes and one read per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbt_oq import sbt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_push i_push,
    output logic      o_room2,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out_item o_item
);

    t_out_item         r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [OQ_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [OQ_CW-1:0]  r_count, n_count;
    logic              pop;
    logic [OQ_AW-1:0]  wr_ptr_1;

    assign o_valid  = (r_count != '0);
    assign o_item   = r_mem[r_rd_ptr];
    assign o_room2  = (r_count <= OQ_CW'(OQ_DEPTH - 2));
    assign pop      = o_valid && !i_stall;
    assign wr_ptr_1 = r_wr_ptr + 1'b1;

    assign n_wr_ptr = r_wr_ptr + OQ_AW'(i_push.cnt);
    assign n_rd_ptr = r_rd_ptr + OQ_AW'(pop);
    assign n_count  = r_count + OQ_CW'(i_push.cnt) - OQ_CW'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/source_byte_tokenizer.sv =====
// ---------------------------------------------------------------------------
// source_byte_tokenizer
// splits a stream of source bytes into identifier, keyword, string,
// punctuation and end-of-file tokens
// ---------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries one t_in_item per transfer:
// a source byte, or the end-of-source command. Output channel o_out_valid /
// i_out_stall carries one t_out_item per transfer; last_of_run marks the
// final token caused by one input transfer (a byte gives zero, one or two
// tokens, end of source gives one or two).
// An accepted item is scanned while it sits in the input register, once the
// queue has room for two tokens, and its tokens are written to the queue at
// the next edge; the first token is then offered from the queue. One byte is
// taken every cycle while the queue has room; a byte that yields two tokens
// needs two output transfers, and a four-entry token queue absorbs that.
// o_in_stall rises only when the queue could not take two more tokens.
// Reset clears the scan state (idle, position 0, line 1) and empties the
// queue. When the receiver stalls, the offered token holds and the queue
// fills; the input stalls once the queue is nearly full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module source_byte_tokenizer import sbt_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    logic     r_in_valid, n_in_valid;
    t_in_item r_in_item;
    logic     room2;
    logic     go;
    logic     in_xfer;
    t_push    push;

    assign go         = r_in_valid && room2;
    assign o_in_stall = r_in_valid && !room2;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign n_in_valid = in_xfer ? 1'b1 : (go ? 1'b0 : r_in_valid);

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    sbt_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_in_item),
        .o_push  (push)
    );

    sbt_oq u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/sbt_chk.sv =====
// ---------------------------------------------------------------------------
// sbt_chk
// port-level checks of the source byte tokenizer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbt_chk import sbt_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_item,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    a_out_valid_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_payload_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_item))
        else $error("output payload changed while stalled");

    a_eof_closes_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.token_kind == KIND_EOF) |->
        (o_out_item.last_of_run && o_out_item.text_length == 16'd0))
        else $error("end of file token not last or not empty");

    a_in_payload_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_item)))
        else $error("input transfer changed while stalled");

    a_line_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.line_number != 16'd0))
        else $error("line number zero");

endmodule

bind source_byte_tokenizer sbt_chk u_sbt_chk (.*);

`default_nettype wire
